@@ rtl/ppbf_pkg.sv @@
// ppbf_pkg: shared types, constants and the per-point step schedule for the
// projected point box fit block; no dependencies

package ppbf_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int MAX_POINTS = 1048576;

	localparam int WORD_W  = 32;
	localparam int CNT_W   = $clog2(MAX_POINTS + 1);
	localparam int NWORDS  = 25;
	localparam int WIDX_W  = 5;
	localparam int MUL_A_W = WORD_W + 2;
	localparam int MUL_B_W = WORD_W;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int ACC_W   = 2 * WORD_W - FRAC_BITS + 2;

	localparam int N_STEPS  = 27;
	localparam int LAST_CYC = N_STEPS + 2;
	localparam int STEP_W   = $clog2(LAST_CYC + 1);

	// frame word layout
	localparam int W_ROT = 0;
	localparam int W_TRN = 9;
	localparam int W_CAM = 12;
	localparam int W_CU  = 21;
	localparam int W_CV  = 22;
	localparam int W_BW  = 23;
	localparam int W_BH  = 24;

	// fixed point constants
	localparam logic signed [WORD_W-1:0] FIX_ONE  = WORD_W'(64'sd1 <<< FRAC_BITS);
	localparam logic signed [WORD_W:0]   MIN_SIZE = (WORD_W + 1)'(((64'sd1 <<< FRAC_BITS) + 50) / 100);
	localparam logic signed [WORD_W:0]   LIFT     = (WORD_W + 1)'(((64'sd1 <<< FRAC_BITS) * 2 + 5) / 10);
	localparam logic signed [WORD_W-1:0] S32_MAX  = {1'b0, {(WORD_W - 1){1'b1}}};
	localparam logic signed [WORD_W-1:0] S32_MIN  = {1'b1, {(WORD_W - 1){1'b0}}};

	// camera and projected vector slots
	localparam int V_CX = 0;
	localparam int V_CY = 1;
	localparam int V_CZ = 2;
	localparam int V_QX = 3;
	localparam int V_QY = 4;
	localparam int V_QZ = 5;
	localparam int NVEC = 6;
	localparam int VIDX_W = $clog2(NVEC);

	typedef enum logic [2:0] {
		OP_NOP,
		OP_FIRST,
		OP_ADD,
		OP_LAST,
		OP_GE_X,
		OP_LE_X,
		OP_GE_Y,
		OP_LE_Y
	} op_t;

	typedef enum logic [2:0] {
		A_WORD,
		A_LOX,
		A_HIX,
		A_LOY,
		A_HIY
	} asel_t;

	typedef enum logic [2:0] {
		B_PX,
		B_PY,
		B_PZ,
		B_ONE,
		B_CX,
		B_CY,
		B_CZ,
		B_QZ
	} bsel_t;

	typedef struct packed {
		op_t               op;
		asel_t             asel;
		bsel_t             bsel;
		logic [WIDX_W-1:0] word;
		logic [VIDX_W-1:0] dst;
	} step_t;

	typedef struct packed {
		logic commit;
		logic pass;
		logic emit;
	} acc_ctl_t;

	function automatic step_t mk_step(input op_t op, input asel_t asel, input bsel_t bsel,
		input int word, input int dst);
		step_t s;
		s.op   = op;
		s.asel = asel;
		s.bsel = bsel;
		s.word = WIDX_W'(word);
		s.dst  = VIDX_W'(dst);
		return s;
	endfunction

	// one multiply per step; camera rows take four (translation times one)
	function automatic step_t step_info(input logic [STEP_W-1:0] idx);
		step_t s;
		unique case (idx)
			STEP_W'(0):  s = mk_step(OP_FIRST, A_WORD, B_PX,  W_ROT + 0, V_CX);
			STEP_W'(1):  s = mk_step(OP_ADD,   A_WORD, B_PY,  W_ROT + 1, V_CX);
			STEP_W'(2):  s = mk_step(OP_ADD,   A_WORD, B_PZ,  W_ROT + 2, V_CX);
			STEP_W'(3):  s = mk_step(OP_LAST,  A_WORD, B_ONE, W_TRN + 0, V_CX);
			STEP_W'(4):  s = mk_step(OP_FIRST, A_WORD, B_PX,  W_ROT + 3, V_CY);
			STEP_W'(5):  s = mk_step(OP_ADD,   A_WORD, B_PY,  W_ROT + 4, V_CY);
			STEP_W'(6):  s = mk_step(OP_ADD,   A_WORD, B_PZ,  W_ROT + 5, V_CY);
			STEP_W'(7):  s = mk_step(OP_LAST,  A_WORD, B_ONE, W_TRN + 1, V_CY);
			STEP_W'(8):  s = mk_step(OP_FIRST, A_WORD, B_PX,  W_ROT + 6, V_CZ);
			STEP_W'(9):  s = mk_step(OP_ADD,   A_WORD, B_PY,  W_ROT + 7, V_CZ);
			STEP_W'(10): s = mk_step(OP_ADD,   A_WORD, B_PZ,  W_ROT + 8, V_CZ);
			STEP_W'(11): s = mk_step(OP_LAST,  A_WORD, B_ONE, W_TRN + 2, V_CZ);
			STEP_W'(12): s = mk_step(OP_FIRST, A_WORD, B_CX,  W_CAM + 0, V_QX);
			STEP_W'(13): s = mk_step(OP_ADD,   A_WORD, B_CY,  W_CAM + 1, V_QX);
			STEP_W'(14): s = mk_step(OP_LAST,  A_WORD, B_CZ,  W_CAM + 2, V_QX);
			STEP_W'(15): s = mk_step(OP_FIRST, A_WORD, B_CX,  W_CAM + 3, V_QY);
			STEP_W'(16): s = mk_step(OP_ADD,   A_WORD, B_CY,  W_CAM + 4, V_QY);
			STEP_W'(17): s = mk_step(OP_LAST,  A_WORD, B_CZ,  W_CAM + 5, V_QY);
			STEP_W'(18): s = mk_step(OP_FIRST, A_WORD, B_CX,  W_CAM + 6, V_QZ);
			STEP_W'(19): s = mk_step(OP_ADD,   A_WORD, B_CY,  W_CAM + 7, V_QZ);
			STEP_W'(20): s = mk_step(OP_LAST,  A_WORD, B_CZ,  W_CAM + 8, V_QZ);
			STEP_W'(23): s = mk_step(OP_GE_X,  A_LOX,  B_QZ,  0, 0);
			STEP_W'(24): s = mk_step(OP_LE_X,  A_HIX,  B_QZ,  0, 0);
			STEP_W'(25): s = mk_step(OP_GE_Y,  A_LOY,  B_QZ,  0, 0);
			STEP_W'(26): s = mk_step(OP_LE_Y,  A_HIY,  B_QZ,  0, 0);
			default:     s = mk_step(OP_NOP,   A_WORD, B_PX,  0, 0);
		endcase
		return s;
	endfunction

endpackage

@@ rtl/ppbf_mul.sv @@
// ppbf_mul: shared signed multiplier with registered operands and product
// depends on ppbf_pkg

module ppbf_mul import ppbf_pkg::*; (
	input  logic                      clk,
	input  logic signed [MUL_A_W-1:0] a,
	input  logic signed [MUL_B_W-1:0] b,
	output logic signed [PROD_W-1:0]  p
);

	logic signed [MUL_A_W-1:0] a_s1;
	logic signed [MUL_B_W-1:0] b_s1;
	logic signed [PROD_W-1:0]  p_s2;

	always_ff @(posedge clk) begin
		a_s1 <= a;
		b_s1 <= b;
		p_s2 <= PROD_W'(a_s1) * PROD_W'(b_s1);
	end

	assign p = p_s2;

endmodule

@@ rtl/ppbf_acc.sv @@
// ppbf_acc: running min/max and count of accepted points, result register
// depends on ppbf_pkg; driven by the sequencer in projected_point_box_fit

module ppbf_acc import ppbf_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  acc_ctl_t                 ctl,
	input  logic signed [WORD_W-1:0] px,
	input  logic signed [WORD_W-1:0] py,
	input  logic signed [WORD_W-1:0] pz,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     found,
	output logic signed [WORD_W-1:0] center_x,
	output logic signed [WORD_W-1:0] center_y,
	output logic signed [WORD_W-1:0] center_z,
	output logic        [WORD_W-1:0] size_x,
	output logic        [WORD_W-1:0] size_y,
	output logic        [WORD_W-1:0] size_z,
	output logic signed [WORD_W-1:0] label_height,
	output logic        [CNT_W-1:0]  inside_count
);

	logic signed [WORD_W-1:0] min_x_q, min_y_q, min_z_q;
	logic signed [WORD_W-1:0] max_x_q, max_y_q, max_z_q;
	logic        [CNT_W-1:0]  count_q;
	logic                     out_valid_q;

	logic                     found_q;
	logic signed [WORD_W-1:0] cx_q, cy_q, cz_q, lh_q;
	logic        [WORD_W-1:0] sx_q, sy_q, sz_q;
	logic        [CNT_W-1:0]  cnt_out_q;

	logic signed [WORD_W:0] sum_x, sum_y, sum_z;
	logic signed [WORD_W:0] dif_x, dif_y, dif_z;
	logic signed [WORD_W:0] lift_z;
	logic        [WORD_W-1:0] sz_x, sz_y, sz_z;
	logic signed [WORD_W-1:0] lh;

	always_comb begin
		sum_x  = {min_x_q[WORD_W-1], min_x_q} + {max_x_q[WORD_W-1], max_x_q};
		sum_y  = {min_y_q[WORD_W-1], min_y_q} + {max_y_q[WORD_W-1], max_y_q};
		sum_z  = {min_z_q[WORD_W-1], min_z_q} + {max_z_q[WORD_W-1], max_z_q};
		dif_x  = {max_x_q[WORD_W-1], max_x_q} - {min_x_q[WORD_W-1], min_x_q};
		dif_y  = {max_y_q[WORD_W-1], max_y_q} - {min_y_q[WORD_W-1], min_y_q};
		dif_z  = {max_z_q[WORD_W-1], max_z_q} - {min_z_q[WORD_W-1], min_z_q};
		lift_z = {max_z_q[WORD_W-1], max_z_q} + LIFT;
		sz_x   = (dif_x < MIN_SIZE) ? MIN_SIZE[WORD_W-1:0] : dif_x[WORD_W-1:0];
		sz_y   = (dif_y < MIN_SIZE) ? MIN_SIZE[WORD_W-1:0] : dif_y[WORD_W-1:0];
		sz_z   = (dif_z < MIN_SIZE) ? MIN_SIZE[WORD_W-1:0] : dif_z[WORD_W-1:0];
		lh     = (lift_z > (WORD_W + 1)'(S32_MAX)) ? S32_MAX : lift_z[WORD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_x_q     <= S32_MAX;
			min_y_q     <= S32_MAX;
			min_z_q     <= S32_MAX;
			max_x_q     <= S32_MIN;
			max_y_q     <= S32_MIN;
			max_z_q     <= S32_MIN;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.emit) begin
				min_x_q     <= S32_MAX;
				min_y_q     <= S32_MAX;
				min_z_q     <= S32_MAX;
				max_x_q     <= S32_MIN;
				max_y_q     <= S32_MIN;
				max_z_q     <= S32_MIN;
				count_q     <= '0;
				out_valid_q <= 1'b1;
			end else begin
				if (out_valid_q && !out_stall) begin
					out_valid_q <= 1'b0;
				end
				if (ctl.commit && ctl.pass) begin
					if (px < min_x_q) min_x_q <= px;
					if (py < min_y_q) min_y_q <= py;
					if (pz < min_z_q) min_z_q <= pz;
					if (px > max_x_q) max_x_q <= px;
					if (py > max_y_q) max_y_q <= py;
					if (pz > max_z_q) max_z_q <= pz;
					if (count_q < CNT_W'(MAX_POINTS)) count_q <= count_q + 1'b1;
				end
			end
		end
	end

	// result payload, zero when nothing fell inside the box
	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			if (count_q != '0) begin
				found_q   <= 1'b1;
				cx_q      <= sum_x[WORD_W:1];
				cy_q      <= sum_y[WORD_W:1];
				cz_q      <= sum_z[WORD_W:1];
				sx_q      <= sz_x;
				sy_q      <= sz_y;
				sz_q      <= sz_z;
				lh_q      <= lh;
				cnt_out_q <= count_q;
			end else begin
				found_q   <= 1'b0;
				cx_q      <= '0;
				cy_q      <= '0;
				cz_q      <= '0;
				sx_q      <= '0;
				sy_q      <= '0;
				sz_q      <= '0;
				lh_q      <= '0;
				cnt_out_q <= '0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign found        = found_q;
	assign center_x     = cx_q;
	assign center_y     = cy_q;
	assign center_z     = cz_q;
	assign size_x       = sx_q;
	assign size_y       = sy_q;
	assign size_z       = sz_q;
	assign label_height = lh_q;
	assign inside_count = cnt_out_q;

endmodule

@@ rtl/projected_point_box_fit.sv @@
// projected_point_box_fit: top level, frame word store, step sequencer and
// accumulate/compare datapath around one shared multiplier
// depends on ppbf_pkg, ppbf_mul and ppbf_acc
//
// usage: one input channel (in_valid/in_stall) carries requests. action 0
// writes word_value into frame word word_index (rotation, translation,
// camera matrix, image box); words above 24 are dropped. such a request is
// taken at once and the block stays ready. action 1 delivers a point: the
// block stalls input while one 34x32 multiplier runs 27 steps (12 for the
// camera transform, 9 for the projection, 4 for the box bound products,
// two idle), so no new point is taken until the current one is through.
// the multiplier's operand and product registers set the step pipeline.
// a point with last_point set adds an emit state that loads the result
// register (out_valid/out_stall) and clears the running min/max and count.
// if the previous result is still stalled, the emit state waits until it
// is taken. reset clears the accumulators, the sequencer and out_valid;
// frame words must be written before the first point.

module projected_point_box_fit import ppbf_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     action,
	input  logic        [4:0]        word_index,
	input  logic signed [WORD_W-1:0] word_value,
	input  logic signed [WORD_W-1:0] point_x,
	input  logic signed [WORD_W-1:0] point_y,
	input  logic signed [WORD_W-1:0] point_z,
	input  logic                     last_point,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     found,
	output logic signed [WORD_W-1:0] center_x,
	output logic signed [WORD_W-1:0] center_y,
	output logic signed [WORD_W-1:0] center_z,
	output logic        [WORD_W-1:0] size_x,
	output logic        [WORD_W-1:0] size_y,
	output logic        [WORD_W-1:0] size_z,
	output logic signed [WORD_W-1:0] label_height,
	output logic        [CNT_W-1:0]  inside_count
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_EMIT
	} state_t;

	state_t              state_q;
	logic [STEP_W-1:0]   cyc_q;
	logic                pass_q;
	logic                last_q;

	logic signed [WORD_W-1:0] fw_q [NWORDS];
	logic signed [WORD_W-1:0] vec_q [NVEC];
	logic signed [WORD_W-1:0] px_q, py_q, pz_q;
	logic signed [ACC_W-1:0]  acc_q;

	logic                      req_ok;
	logic                      emit_ok;
	step_t                     is_step;
	step_t                     ps_step;
	logic signed [MUL_A_W-1:0] lox, hix, loy, hiy;
	logic signed [MUL_A_W-1:0] op_a;
	logic signed [MUL_B_W-1:0] op_b;
	logic signed [PROD_W-1:0]  prod;
	logic signed [ACC_W-1:0]   pshift;
	logic signed [ACC_W-1:0]   acc_sum;
	logic signed [WORD_W-1:0]  sat_val;
	logic signed [PROD_W-1:0]  num_x, num_y;
	acc_ctl_t                  ctl;

	assign in_stall = (state_q != ST_IDLE);
	assign req_ok   = in_valid && !in_stall;
	assign emit_ok  = !out_valid || !out_stall;

	// box bounds scaled by two: 2c - s and 2c + s
	always_comb begin
		lox = ({{2{fw_q[W_CU][WORD_W-1]}}, fw_q[W_CU]} <<< 1)
			- {{2{fw_q[W_BW][WORD_W-1]}}, fw_q[W_BW]};
		hix = ({{2{fw_q[W_CU][WORD_W-1]}}, fw_q[W_CU]} <<< 1)
			+ {{2{fw_q[W_BW][WORD_W-1]}}, fw_q[W_BW]};
		loy = ({{2{fw_q[W_CV][WORD_W-1]}}, fw_q[W_CV]} <<< 1)
			- {{2{fw_q[W_BH][WORD_W-1]}}, fw_q[W_BH]};
		hiy = ({{2{fw_q[W_CV][WORD_W-1]}}, fw_q[W_CV]} <<< 1)
			+ {{2{fw_q[W_BH][WORD_W-1]}}, fw_q[W_BH]};
	end

	// operand issue
	always_comb begin
		is_step = step_info(cyc_q);
		unique case (is_step.asel)
			A_LOX:   op_a = lox;
			A_HIX:   op_a = hix;
			A_LOY:   op_a = loy;
			A_HIY:   op_a = hiy;
			default: op_a = {{2{fw_q[is_step.word][WORD_W-1]}}, fw_q[is_step.word]};
		endcase
		unique case (is_step.bsel)
			B_PX:    op_b = px_q;
			B_PY:    op_b = py_q;
			B_PZ:    op_b = pz_q;
			B_ONE:   op_b = FIX_ONE;
			B_CX:    op_b = vec_q[V_CX];
			B_CY:    op_b = vec_q[V_CY];
			B_CZ:    op_b = vec_q[V_CZ];
			B_QZ:    op_b = vec_q[V_QZ];
			default: op_b = px_q;
		endcase
	end

	ppbf_mul u_mul (
		.clk (clk),
		.a   (op_a),
		.b   (op_b),
		.p   (prod)
	);

	// product of the step whose operands have passed the multiplier's operand and product registers
	always_comb begin
		ps_step = step_info(cyc_q - STEP_W'(2));
		pshift  = prod[FRAC_BITS+ACC_W-1:FRAC_BITS];
		acc_sum = acc_q + pshift;
		if (acc_sum > ACC_W'(S32_MAX)) begin
			sat_val = S32_MAX;
		end else if (acc_sum < ACC_W'(S32_MIN)) begin
			sat_val = S32_MIN;
		end else begin
			sat_val = acc_sum[WORD_W-1:0];
		end
		num_x = {{(PROD_W - WORD_W - FRAC_BITS - 1){vec_q[V_QX][WORD_W-1]}},
			vec_q[V_QX], {(FRAC_BITS + 1){1'b0}}};
		num_y = {{(PROD_W - WORD_W - FRAC_BITS - 1){vec_q[V_QY][WORD_W-1]}},
			vec_q[V_QY], {(FRAC_BITS + 1){1'b0}}};
	end

	// frame words, point and datapath registers
	always_ff @(posedge clk) begin
		if (req_ok && !action && (word_index < WIDX_W'(NWORDS))) begin
			fw_q[word_index] <= word_value;
		end
		if (req_ok && action) begin
			px_q <= point_x;
			py_q <= point_y;
			pz_q <= point_z;
		end
		if (state_q == ST_RUN) begin
			unique case (ps_step.op)
				OP_FIRST: acc_q <= pshift;
				OP_ADD:   acc_q <= acc_sum;
				OP_LAST:  vec_q[ps_step.dst] <= sat_val;
				default:  ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cyc_q   <= '0;
			pass_q  <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_ok && action) begin
						state_q <= ST_RUN;
						cyc_q   <= '0;
						pass_q  <= 1'b1;
						last_q  <= last_point;
					end
				end
				ST_RUN: begin
					unique case (ps_step.op)
						OP_GE_X: if (num_x < prod) pass_q <= 1'b0;
						OP_LE_X: if (num_x > prod) pass_q <= 1'b0;
						OP_GE_Y: if (num_y < prod) pass_q <= 1'b0;
						OP_LE_Y: if (num_y > prod) pass_q <= 1'b0;
						default: ;
					endcase
					if (cyc_q == STEP_W'(LAST_CYC)) begin
						state_q <= last_q ? ST_EMIT : ST_IDLE;
					end else begin
						cyc_q <= cyc_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (emit_ok) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		ctl.commit = (state_q == ST_RUN) && (cyc_q == STEP_W'(LAST_CYC));
		ctl.pass   = pass_q && (vec_q[V_QZ] > 0);
		ctl.emit   = (state_q == ST_EMIT) && emit_ok;
	end

	ppbf_acc u_acc (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.px           (px_q),
		.py           (py_q),
		.pz           (pz_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.found        (found),
		.center_x     (center_x),
		.center_y     (center_y),
		.center_z     (center_z),
		.size_x       (size_x),
		.size_y       (size_y),
		.size_z       (size_z),
		.label_height (label_height),
		.inside_count (inside_count)
	);

endmodule

@@ dv/tb_top.sv @@
// tb_top: self-checking bench for projected_point_box_fit; loads camera frames,
// streams lidar clouds and checks every box fit result field by field
// depends on ppbf_pkg and the projected_point_box_fit rtl

module tb_top;
	import ppbf_pkg::*;

	localparam int ITEMS_WANTED   = 1230;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 40;
	localparam int MIN_FIT        = ((1 << FRAC_BITS) + 50) / 100;
	localparam longint LABEL_LIFT = ((64'sd1 <<< FRAC_BITS) * 2 + 5) / 10;
	localparam int FIX_UNIT       = 1 << FRAC_BITS;
	localparam logic signed [WORD_W-1:0] TOP    = 32'sh7fffffff;
	localparam logic signed [WORD_W-1:0] BOTTOM = 32'sh80000000;

	typedef struct {
		logic                     act;
		logic [4:0]               widx;
		logic signed [WORD_W-1:0] wval;
		logic signed [WORD_W-1:0] px;
		logic signed [WORD_W-1:0] py;
		logic signed [WORD_W-1:0] pz;
		logic                     last;
		bit                       drain;
	} req_t;

	typedef struct {
		logic                     found;
		logic signed [WORD_W-1:0] cx;
		logic signed [WORD_W-1:0] cy;
		logic signed [WORD_W-1:0] cz;
		logic [WORD_W-1:0]        sx;
		logic [WORD_W-1:0]        sy;
		logic [WORD_W-1:0]        sz;
		logic signed [WORD_W-1:0] lh;
		logic [CNT_W-1:0]         cnt;
	} fit_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic                     action = 1'b0;
	logic [4:0]               word_index = '0;
	logic signed [WORD_W-1:0] word_value = '0;
	logic signed [WORD_W-1:0] point_x = '0;
	logic signed [WORD_W-1:0] point_y = '0;
	logic signed [WORD_W-1:0] point_z = '0;
	logic                     last_point = 1'b0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic                     found;
	logic signed [WORD_W-1:0] center_x;
	logic signed [WORD_W-1:0] center_y;
	logic signed [WORD_W-1:0] center_z;
	logic [WORD_W-1:0]        size_x;
	logic [WORD_W-1:0]        size_y;
	logic [WORD_W-1:0]        size_z;
	logic signed [WORD_W-1:0] label_height;
	logic [CNT_W-1:0]         inside_count;

	projected_point_box_fit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.word_index   (word_index),
		.word_value   (word_value),
		.point_x      (point_x),
		.point_y      (point_y),
		.point_z      (point_z),
		.last_point   (last_point),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.found        (found),
		.center_x     (center_x),
		.center_y     (center_y),
		.center_z     (center_z),
		.size_x       (size_x),
		.size_y       (size_y),
		.size_z       (size_z),
		.label_height (label_height),
		.inside_count (inside_count)
	);

	// predicted block state
	logic signed [WORD_W-1:0] frame_w [NWORDS];
	logic signed [WORD_W-1:0] lo_x = TOP, lo_y = TOP, lo_z = TOP;
	logic signed [WORD_W-1:0] hi_x = BOTTOM, hi_y = BOTTOM, hi_z = BOTTOM;
	int                       n_inside = 0;

	req_t pending_reqs [$];
	fit_t box_fits_due [$];
	int   n_real = 0;
	int   n_total = 0;
	int   n_taken = 0;
	int   fits_owed = 0;
	int   fits_seen = 0;
	int   n_bad = 0;
	int   idle_cycles = 0;
	req_t cur;
	fit_t want;
	bit   made;
	bit   hold;
	int   owed_now;
	bit   quiet;

	assign quiet = (n_taken >= 500) && (n_taken < 800);

	function automatic longint fx_mul(input logic signed [WORD_W-1:0] a,
		input logic signed [WORD_W-1:0] b);
		return (longint'(a) * longint'(b)) >>> FRAC_BITS;
	endfunction

	function automatic logic signed [WORD_W-1:0] clip32(input longint v);
		if (v > 64'sd2147483647)
			return TOP;
		if (v < -64'sd2147483648)
			return BOTTOM;
		return 32'(v);
	endfunction

	function automatic logic signed [WORD_W-1:0] row_sum(input int base,
		input logic signed [WORD_W-1:0] a, b, c, add);
		return clip32(fx_mul(frame_w[base], a) + fx_mul(frame_w[base + 1], b)
			+ fx_mul(frame_w[base + 2], c) + longint'(add));
	endfunction

	// 2*q*2^F inside [(2c - s)*qz, (2c + s)*qz], exact
	function automatic bit in_span(input logic signed [WORD_W-1:0] q, qz, c, s);
		logic signed [79:0] num;
		logic signed [79:0] lo;
		logic signed [79:0] hi;
		num = 80'(q) <<< (FRAC_BITS + 1);
		lo  = 80'(c) * 2 - 80'(s);
		hi  = 80'(c) * 2 + 80'(s);
		return (num >= lo * 80'(qz)) && (num <= hi * 80'(qz));
	endfunction

	function automatic logic signed [WORD_W-1:0] mid_of(input logic signed [WORD_W-1:0] lo,
		input logic signed [WORD_W-1:0] hi);
		logic signed [WORD_W:0] s;
		s = 33'(lo) + 33'(hi);
		return s[WORD_W:1];
	endfunction

	function automatic logic [WORD_W-1:0] span_of(input logic signed [WORD_W-1:0] lo,
		input logic signed [WORD_W-1:0] hi);
		logic signed [WORD_W:0] d;
		d = 33'(hi) - 33'(lo);
		if (d < MIN_FIT)
			d = MIN_FIT;
		return d[WORD_W-1:0];
	endfunction

	// applies one request to the predicted state, returns 1 when a fit is due
	function automatic bit predict_box_fit(input req_t r);
		logic signed [WORD_W-1:0] cx, cy, cz, qx, qy, qz;
		fit_t f;
		if (!r.act) begin
			if (r.widx < NWORDS)
				frame_w[r.widx] = r.wval;
			return 1'b0;
		end
		cx = row_sum(W_ROT + 0, r.px, r.py, r.pz, frame_w[W_TRN + 0]);
		cy = row_sum(W_ROT + 3, r.px, r.py, r.pz, frame_w[W_TRN + 1]);
		cz = row_sum(W_ROT + 6, r.px, r.py, r.pz, frame_w[W_TRN + 2]);
		qx = row_sum(W_CAM + 0, cx, cy, cz, '0);
		qy = row_sum(W_CAM + 3, cx, cy, cz, '0);
		qz = row_sum(W_CAM + 6, cx, cy, cz, '0);
		if (qz > 0 && in_span(qx, qz, frame_w[W_CU], frame_w[W_BW])
				&& in_span(qy, qz, frame_w[W_CV], frame_w[W_BH])) begin
			if (r.px < lo_x) lo_x = r.px;
			if (r.py < lo_y) lo_y = r.py;
			if (r.pz < lo_z) lo_z = r.pz;
			if (r.px > hi_x) hi_x = r.px;
			if (r.py > hi_y) hi_y = r.py;
			if (r.pz > hi_z) hi_z = r.pz;
			if (n_inside < MAX_POINTS)
				n_inside++;
		end
		if (!r.last)
			return 1'b0;
		f = '{default: 0};
		if (n_inside != 0) begin
			f.found = 1'b1;
			f.cx    = mid_of(lo_x, hi_x);
			f.cy    = mid_of(lo_y, hi_y);
			f.cz    = mid_of(lo_z, hi_z);
			f.sx    = span_of(lo_x, hi_x);
			f.sy    = span_of(lo_y, hi_y);
			f.sz    = span_of(lo_z, hi_z);
			f.lh    = clip32(longint'(hi_z) + LABEL_LIFT);
			f.cnt   = CNT_W'(n_inside);
		end
		box_fits_due = {box_fits_due, f};
		lo_x = TOP; lo_y = TOP; lo_z = TOP;
		hi_x = BOTTOM; hi_y = BOTTOM; hi_z = BOTTOM;
		n_inside = 0;
		return 1'b1;
	endfunction

	task automatic check_field(input string name, input logic [WORD_W-1:0] exp_v,
		input logic [WORD_W-1:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s: expected %h, got %h", name, exp_v, got_v);
			n_bad++;
		end
	endtask

	function automatic int jitter(input int a);
		return int'($urandom_range(0, 2 * a)) - a;
	endfunction

	task automatic add_req(input logic act, input logic [4:0] widx,
		input logic signed [WORD_W-1:0] wval, px, py, pz, input logic last, input bit drain);
		req_t r;
		r.act   = act;
		r.widx  = widx;
		r.wval  = wval;
		r.px    = px;
		r.py    = py;
		r.pz    = pz;
		r.last  = last;
		r.drain = drain;
		pending_reqs = {pending_reqs, r};
		if (act || widx < NWORDS)
			n_real++;
	endtask

	task automatic put_word(input int idx, input logic signed [WORD_W-1:0] v,
		input logic last);
		add_req(1'b0, 5'(idx), v, $urandom, $urandom, $urandom, last, 1'b0);
	endtask

	task automatic put_point(input logic signed [WORD_W-1:0] px, py, pz,
		input logic last, input bit drain);
		add_req(1'b1, 5'($urandom_range(0, 31)), $urandom, px, py, pz, last, drain);
	endtask

	// lidar x forward, camera z forward; point spread keeps many inside the box
	task automatic put_scene_point(input logic last, input bit drain);
		int d;
		int y;
		int z;
		d = $urandom_range(FIX_UNIT / 2, 20 * FIX_UNIT);
		y = jitter(d / 2);
		z = jitter(d / 2);
		if ($urandom_range(0, 9) == 0)
			d = -d;
		put_point(d, y, z, last, drain);
	endtask

	task automatic load_scene(input bit centered);
		logic signed [WORD_W-1:0] w [NWORDS];
		int j;
		for (j = 0; j < NWORDS; j++)
			w[j] = '0;
		w[W_ROT + 1] = -FIX_UNIT;
		w[W_ROT + 5] = -FIX_UNIT;
		w[W_ROT + 6] = FIX_UNIT;
		if (!centered) begin
			for (j = 0; j < 9; j++)
				w[W_ROT + j] = w[W_ROT + j] + jitter(FIX_UNIT / 20);
			for (j = 0; j < 3; j++)
				w[W_TRN + j] = jitter(FIX_UNIT / 2);
			w[W_CAM + 1] = jitter(FIX_UNIT / 4);
		end
		w[W_CAM + 0] = $urandom_range(50, 400) * FIX_UNIT + $urandom_range(0, FIX_UNIT - 1);
		w[W_CAM + 2] = $urandom_range(100, 300) * FIX_UNIT + $urandom_range(0, FIX_UNIT - 1);
		w[W_CAM + 4] = $urandom_range(50, 400) * FIX_UNIT + $urandom_range(0, FIX_UNIT - 1);
		w[W_CAM + 5] = $urandom_range(100, 300) * FIX_UNIT + $urandom_range(0, FIX_UNIT - 1);
		w[W_CAM + 8] = FIX_UNIT;
		if (centered) begin
			w[W_CU] = w[W_CAM + 2];
			w[W_CV] = w[W_CAM + 5];
			w[W_BW] = $urandom_range(400, 600) * FIX_UNIT;
			w[W_BH] = $urandom_range(400, 600) * FIX_UNIT;
		end else begin
			w[W_CU] = w[W_CAM + 2] + jitter(100 * FIX_UNIT);
			w[W_CV] = w[W_CAM + 5] + jitter(100 * FIX_UNIT);
			w[W_BW] = $urandom_range(20 * FIX_UNIT, 400 * FIX_UNIT);
			w[W_BH] = $urandom_range(20 * FIX_UNIT, 400 * FIX_UNIT);
			if ($urandom_range(0, 9) == 0)
				w[W_BW] = -w[W_BW];
			if ($urandom_range(0, 9) == 0)
				w[W_BH] = -w[W_BH];
		end
		for (j = 0; j < NWORDS; j++)
			put_word(j, w[j], $urandom_range(0, 1));
	endtask

	task automatic build_stimulus();
		int k;
		int npts;
		int r;
		bit first;
		logic lastp;
		bit pause;
		// directed part
		load_scene(1'b1);
		put_word(25, TOP, 1'b1);
		put_word(31, BOTTOM, 1'b0);
		put_word(W_TRN + 0, '0, 1'b1);
		put_point(5 * FIX_UNIT, 0, 0, 1'b0, 1'b0);
		put_point(-5 * FIX_UNIT, 0, 0, 1'b0, 1'b0);
		put_point(5 * FIX_UNIT, 0, 0, 1'b1, 1'b0);
		put_point(-5 * FIX_UNIT, 0, 0, 1'b1, 1'b0);
		// z no longer moves the image point
		put_word(W_ROT + 5, '0, 1'b0);
		put_point(5 * FIX_UNIT, 0, TOP, 1'b0, 1'b0);
		put_point(5 * FIX_UNIT, 0, BOTTOM, 1'b1, 1'b0);
		put_point(TOP, TOP, TOP, 1'b0, 1'b1);
		put_point(BOTTOM, BOTTOM, BOTTOM, 1'b1, 1'b0);
		put_word(W_BW, BOTTOM, 1'b0);
		put_point(5 * FIX_UNIT, 0, 0, 1'b1, 1'b0);
		put_word(W_BW, TOP, 1'b0);
		put_word(W_BH, TOP, 1'b0);
		put_point(5 * FIX_UNIT, 0, 0, 1'b1, 1'b0);
		// random clouds
		first = 1'b1;
		while (n_real < ITEMS_WANTED) begin
			if (first || $urandom_range(0, 3) == 0)
				load_scene(1'b0);
			first = 1'b0;
			npts = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 10);
			for (k = 0; k < npts; k++) begin
				r     = $urandom_range(0, 99);
				lastp = (k == npts - 1);
				pause = ($urandom_range(0, 149) == 0);
				if (r < 5) begin
					put_point($urandom, $urandom, $urandom, lastp, pause);
				end else begin
					if (r < 8)
						put_word($urandom_range(NWORDS, 31), $urandom, $urandom_range(0, 1));
					else if (r < 10)
						put_word($urandom_range(0, NWORDS - 1), $urandom, $urandom_range(0, 1));
					put_scene_point(lastp, pause);
				end
			end
		end
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	// request driver and predictor hook
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			action     <= 1'b0;
			word_index <= '0;
			word_value <= '0;
			point_x    <= '0;
			point_y    <= '0;
			point_z    <= '0;
			last_point <= 1'b0;
			n_taken    <= 0;
			fits_owed  <= 0;
		end else begin
			made = 1'b0;
			if (in_valid && !in_stall) begin
				made = predict_box_fit(cur);
				n_taken <= n_taken + 1;
				if (made)
					fits_owed <= fits_owed + 1;
			end
			if (!in_valid || !in_stall) begin
				owed_now = fits_owed + int'(made);
				hold     = 1'b0;
				if (pending_reqs.size() != 0)
					hold = pending_reqs[0].drain && (fits_seen != owed_now);
				if (pending_reqs.size() != 0 && !hold
						&& (quiet || $urandom_range(0, 99) >= 14)) begin
					cur = pending_reqs.pop_front();
					in_valid   <= 1'b1;
					action     <= cur.act;
					word_index <= cur.widx;
					word_value <= cur.wval;
					point_x    <= cur.px;
					point_y    <= cur.py;
					point_z    <= cur.pz;
					last_point <= cur.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			fits_seen <= 0;
		end else begin
			out_stall <= !quiet && ($urandom_range(0, 99) < 14);
			if (out_valid && !out_stall) begin
				if (fits_seen == fits_owed) begin
					$error("result with no box fit pending");
					n_bad++;
				end else begin
					want = box_fits_due.pop_front();
					fits_seen <= fits_seen + 1;
					check_field("found", 32'(want.found), 32'(found));
					check_field("center_x", want.cx, center_x);
					check_field("center_y", want.cy, center_y);
					check_field("center_z", want.cz, center_z);
					check_field("size_x", want.sx, size_x);
					check_field("size_y", want.sy, size_y);
					check_field("size_z", want.sz, size_z);
					check_field("label_height", want.lh, label_height);
					check_field("inside_count", 32'(want.cnt), 32'(inside_count));
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		for (int j = 0; j < NWORDS; j++)
			frame_w[j] = '0;
		build_stimulus();
		n_total = pending_reqs.size();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		while (n_taken != n_total)
			@(posedge clk);
		while (fits_seen != fits_owed)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (box_fits_due.size() != 0) begin
			$error("box fits never delivered: %0d", box_fits_due.size());
			n_bad++;
		end
		if (n_bad == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
